// ----- rtl/aabb_pkg.sv -----
// Shared types, widths and codes for the AABB intersection tester.
// No dependencies; every other file of the block refers to this package.
package aabb_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int IN_W   = 32;   // coordinate port width
    localparam int SIZE_W = 31;   // size and radius width
    localparam int CMD_W  = 2;
    localparam int IDX_W  = 3;
    localparam int NUM_REGS = 6;
    localparam int EXT_W  = 34;   // signed extents and differences
    localparam int MAG_W  = 33;   // magnitude of a difference
    localparam int FRAC_W = 16;
    localparam int NUM_W  = MAG_W + FRAC_W;  // dividend magnitude
    localparam int DEN_W  = 32;   // divisor magnitude
    localparam int T_W    = 41;   // signed, saturated ray parameter
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int RR_W   = 2 * SIZE_W;

    localparam logic signed [T_W-1:0] T_LIMIT = 41'sd655360000000;

    localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_SIZE_X   = 3'd3;
    localparam logic [IDX_W-1:0] REG_SIZE_Y   = 3'd4;
    localparam logic [IDX_W-1:0] REG_SIZE_Z   = 3'd5;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 31'd65536;

    typedef enum logic [CMD_W-1:0] {
        CMD_SPHERE = 2'd0,
        CMD_BOX    = 2'd1,
        CMD_RAY    = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    // Per-axis terms prepared for the sphere, box and slab paths.
    typedef struct packed {
        logic [MAG_W-1:0] clamp_dist;
        logic [NUM_W-1:0] num_a;
        logic [NUM_W-1:0] num_b;
        logic [DEN_W-1:0] den;
        logic             neg_a;
        logic             neg_b;
        logic             box_ok;
        logic             zero;
        logic             in_slab;
    } axis_t;

    // Control bits that ride alongside the divider pipeline.
    typedef struct packed {
        logic       valid;
        logic [CMD_W-1:0] cmd;
        logic       box_hit;
        logic       zero_ok;
        logic [2:0] zero_dir;
        logic [2:0] neg_a;
        logic [2:0] neg_b;
    } side_t;

endpackage

// ----- rtl/aabb_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on aabb_pkg for default widths.
module aabb_div #(
    parameter int NW = aabb_pkg::NUM_W,
    parameter int DW = aabb_pkg::DEN_W
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo
);

    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] num_reg [NW];
    logic [NW-1:0] quo_reg [NW];
    logic [DW-1:0] den_reg [NW];

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [NW-1:0] num_in;
        logic [NW-1:0] quo_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          take;

        if (i == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = num;
            assign quo_in = '0;
            assign den_in = den;
        end
        else begin : g_next
            assign rem_in = rem_reg[i-1];
            assign num_in = num_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign den_in = den_reg[i-1];
        end

        assign trial = {rem_in, num_in[NW-1]};
        assign take  = trial >= {1'b0, den_in};
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= take ? diff[DW-1:0] : trial[DW-1:0];
                num_reg[i] <= {num_in[NW-2:0], 1'b0};
                quo_reg[i] <= {quo_in[NW-2:0], take};
                den_reg[i] <= den_in;
            end
        end
    end

    assign quo = quo_reg[NW-1];

endmodule

// ----- rtl/aabb_prep.sv -----
// Per-axis preparation stage: clamp distance, overlap test, slab dividends.
// Depends on aabb_pkg for widths and axis_t.
module aabb_prep (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [aabb_pkg::EXT_W-1:0]    lo,
    input  logic signed [aabb_pkg::EXT_W-1:0]    hi,
    input  logic signed [aabb_pkg::EXT_W-1:0]    a,
    input  logic signed [aabb_pkg::EXT_W-1:0]    b,
    output aabb_pkg::axis_t                      axis_reg
);

    logic signed [aabb_pkg::EXT_W-1:0] na;
    logic signed [aabb_pkg::EXT_W-1:0] nb;
    logic signed [aabb_pkg::EXT_W-1:0] over;
    logic signed [aabb_pkg::EXT_W-1:0] abs_a;
    logic signed [aabb_pkg::EXT_W-1:0] abs_b;
    logic signed [aabb_pkg::EXT_W-1:0] abs_d;
    logic                              below;
    logic                              above;
    aabb_pkg::axis_t                   axis_next;

    assign na    = lo - a;
    assign nb    = hi - a;
    assign over  = a - hi;
    assign below = a < lo;
    assign above = a > hi;
    assign abs_a = na[aabb_pkg::EXT_W-1] ? -na : na;
    assign abs_b = nb[aabb_pkg::EXT_W-1] ? -nb : nb;
    assign abs_d = b[aabb_pkg::EXT_W-1] ? -b : b;

    always_comb
    begin
        axis_next.clamp_dist = below ? na[aabb_pkg::MAG_W-1:0]
                             : above ? over[aabb_pkg::MAG_W-1:0] : '0;
        axis_next.num_a   = {abs_a[aabb_pkg::MAG_W-1:0], {aabb_pkg::FRAC_W{1'b0}}};
        axis_next.num_b   = {abs_b[aabb_pkg::MAG_W-1:0], {aabb_pkg::FRAC_W{1'b0}}};
        axis_next.den     = abs_d[aabb_pkg::DEN_W-1:0];
        axis_next.neg_a   = na[aabb_pkg::EXT_W-1] ^ b[aabb_pkg::EXT_W-1];
        axis_next.neg_b   = nb[aabb_pkg::EXT_W-1] ^ b[aabb_pkg::EXT_W-1];
        axis_next.box_ok  = !(lo > b) && !above;
        axis_next.zero    = (b == '0);
        axis_next.in_slab = !below && !above;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            axis_reg <= axis_next;
        end
    end

endmodule

// ----- rtl/aabb_intersection_tester_top.sv -----
// An item passes stage 1, stage 2, the slab dividers, post 1, post 2 and the
// output register. Throughput: one item per cycle; the 49-stage slab
// dividers (one quotient bit per stage) set the depth, not the rate.
// A stall on the output freezes the whole pipeline; nothing is lost.
// Reset (rst_n, async, active low) clears all valid bits and loads the box
// registers with center 0 and size 1.0.
module aabb_intersection_tester_top #(
    parameter int COORD_WIDTH = aabb_pkg::COORD_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_write,
    input  logic [aabb_pkg::IDX_W-1:0]       cfg_index,
    input  logic [aabb_pkg::IN_W-1:0]        cfg_data,
    // query channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [aabb_pkg::CMD_W-1:0]       command,
    input  logic signed [aabb_pkg::IN_W-1:0] operand_a_x,
    input  logic signed [aabb_pkg::IN_W-1:0] operand_a_y,
    input  logic signed [aabb_pkg::IN_W-1:0] operand_a_z,
    input  logic signed [aabb_pkg::IN_W-1:0] operand_b_x,
    input  logic signed [aabb_pkg::IN_W-1:0] operand_b_y,
    input  logic signed [aabb_pkg::IN_W-1:0] operand_b_z,
    input  logic [aabb_pkg::SIZE_W-1:0]      radius,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             hit
);

    // Coordinates use only the low CW bits of each field, sign-extended.
    localparam int CW    = (COORD_WIDTH < aabb_pkg::IN_W) ? COORD_WIDTH : aabb_pkg::IN_W;
    localparam int EXT_W = aabb_pkg::EXT_W;
    localparam int NW    = aabb_pkg::NUM_W;
    localparam int T_W   = aabb_pkg::T_W;
    localparam logic [NW-1:0] T_LIM_Q = NW'(aabb_pkg::T_LIMIT);

    // ------------------------------------------------------------------
    // Box registers and extents
    // ------------------------------------------------------------------
    logic [aabb_pkg::IN_W-1:0]   center_reg [3];
    logic [aabb_pkg::SIZE_W-1:0] size_reg   [3];
    logic signed [EXT_W-1:0]     lo_reg [3];
    logic signed [EXT_W-1:0]     hi_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                center_reg[i] <= '0;
                size_reg[i]   <= aabb_pkg::SIZE_RESET;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                aabb_pkg::REG_CENTER_X: center_reg[0] <= cfg_data;
                aabb_pkg::REG_CENTER_Y: center_reg[1] <= cfg_data;
                aabb_pkg::REG_CENTER_Z: center_reg[2] <= cfg_data;
                aabb_pkg::REG_SIZE_X:   size_reg[0]   <= cfg_data[aabb_pkg::SIZE_W-1:0];
                aabb_pkg::REG_SIZE_Y:   size_reg[1]   <= cfg_data[aabb_pkg::SIZE_W-1:0];
                aabb_pkg::REG_SIZE_Z:   size_reg[2]   <= cfg_data[aabb_pkg::SIZE_W-1:0];
                default: ;  // drop writes past the last register
            endcase
        end
    end

    // Registered extents. User moves config only when idle; not enforced.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            lo_reg[i] <= {{(EXT_W-CW){center_reg[i][CW-1]}}, center_reg[i][CW-1:0]}
                         - EXT_W'(size_reg[i][aabb_pkg::SIZE_W-1:1]);
            hi_reg[i] <= {{(EXT_W-CW){center_reg[i][CW-1]}}, center_reg[i][CW-1:0]}
                         + EXT_W'(size_reg[i][aabb_pkg::SIZE_W-1:1]);
        end
    end

    // ------------------------------------------------------------------
    // Global advance: the whole pipe moves when the output can take an item
    // ------------------------------------------------------------------
    logic adv;
    logic out_valid_reg;
    logic hit_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // ------------------------------------------------------------------
    // Stage 1: capture the item and sign-extend the coordinates
    // ------------------------------------------------------------------
    logic                          v1_reg;
    logic [aabb_pkg::CMD_W-1:0]    cmd1_reg;
    logic signed [EXT_W-1:0]       a1_reg [3];
    logic signed [EXT_W-1:0]       b1_reg [3];
    logic [aabb_pkg::SIZE_W-1:0]   rad1_reg;
    logic [aabb_pkg::IN_W-1:0]     a_in [3];
    logic [aabb_pkg::IN_W-1:0]     b_in [3];

    assign a_in[0] = operand_a_x;
    assign a_in[1] = operand_a_y;
    assign a_in[2] = operand_a_z;
    assign b_in[0] = operand_b_x;
    assign b_in[1] = operand_b_y;
    assign b_in[2] = operand_b_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd1_reg <= command;
            rad1_reg <= radius;
            for (int i = 0; i < 3; i++)
            begin
                a1_reg[i] <= {{(EXT_W-CW){a_in[i][CW-1]}}, a_in[i][CW-1:0]};
                b1_reg[i] <= {{(EXT_W-CW){b_in[i][CW-1]}}, b_in[i][CW-1:0]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: per-axis preparation
    // ------------------------------------------------------------------
    aabb_pkg::axis_t              axis [3];
    logic                         v2_reg;
    logic [aabb_pkg::CMD_W-1:0]   cmd2_reg;
    logic [aabb_pkg::SIZE_W-1:0]  rad2_reg;

    for (genvar i = 0; i < 3; i++) begin : g_axis
        aabb_prep u_prep (
            .clk      (clk),
            .en       (adv),
            .lo       (lo_reg[i]),
            .hi       (hi_reg[i]),
            .a        (a1_reg[i]),
            .b        (b1_reg[i]),
            .axis_reg (axis[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd2_reg <= cmd1_reg;
            rad2_reg <= rad1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Slab dividers: |dividend| / |direction| for both slab planes per axis
    // ------------------------------------------------------------------
    logic [NW-1:0] qa [3];
    logic [NW-1:0] qb [3];

    for (genvar i = 0; i < 3; i++) begin : g_div
        aabb_div u_div_a (
            .clk (clk),
            .en  (adv),
            .num (axis[i].num_a),
            .den (axis[i].den),
            .quo (qa[i])
        );
        aabb_div u_div_b (
            .clk (clk),
            .en  (adv),
            .num (axis[i].num_b),
            .den (axis[i].den),
            .quo (qb[i])
        );
    end

    // Control bits travel beside the dividers, one entry per divider stage.
    aabb_pkg::side_t side_in;
    aabb_pkg::side_t side_reg [NW];

    always_comb
    begin
        side_in.valid   = v2_reg;
        side_in.cmd     = cmd2_reg;
        side_in.box_hit = axis[0].box_ok && axis[1].box_ok && axis[2].box_ok;
        // A zero direction is only allowed when the origin sits in the slab.
        side_in.zero_ok = (!axis[0].zero || axis[0].in_slab)
                       && (!axis[1].zero || axis[1].in_slab)
                       && (!axis[2].zero || axis[2].in_slab);
        for (int i = 0; i < 3; i++)
        begin
            side_in.zero_dir[i] = axis[i].zero;
            side_in.neg_a[i]    = axis[i].neg_a;
            side_in.neg_b[i]    = axis[i].neg_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NW; k++)
            begin
                side_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < NW; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Sphere path: square, sum, compare, then delay to meet the dividers
    // ------------------------------------------------------------------
    logic [aabb_pkg::SQ_W-1:0]  sq_reg [3];
    logic [aabb_pkg::RR_W-1:0]  rr3_reg;
    logic [aabb_pkg::SUM_W-1:0] sum_reg;
    logic [aabb_pkg::RR_W-1:0]  rr4_reg;
    logic                       sph_reg [NW-2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= axis[i].clamp_dist * axis[i].clamp_dist;
            end
            rr3_reg <= rad2_reg * rad2_reg;
            sum_reg <= aabb_pkg::SUM_W'(sq_reg[0]) + aabb_pkg::SUM_W'(sq_reg[1])
                     + aabb_pkg::SUM_W'(sq_reg[2]);
            rr4_reg <= rr3_reg;
            // Touching counts as a hit.
            sph_reg[0] <= sum_reg <= aabb_pkg::SUM_W'(rr4_reg);
            for (int k = 1; k < NW - 2; k++)
            begin
                sph_reg[k] <= sph_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Post 1: apply signs and saturate t to the slab limits
    // ------------------------------------------------------------------
    logic signed [T_W-1:0] ta_reg [3];
    logic signed [T_W-1:0] tb_reg [3];
    logic signed [T_W-1:0] ta_mag [3];
    logic signed [T_W-1:0] tb_mag [3];
    aabb_pkg::side_t       p1_side_reg;
    logic                  p1_sph_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ta_mag[i] = (qa[i] > T_LIM_Q) ? aabb_pkg::T_LIMIT : T_W'(qa[i]);
            tb_mag[i] = (qb[i] > T_LIM_Q) ? aabb_pkg::T_LIMIT : T_W'(qb[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_side_reg <= '0;
        end
        else if (adv)
        begin
            p1_side_reg <= side_reg[NW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_sph_reg <= sph_reg[NW-3];
            for (int i = 0; i < 3; i++)
            begin
                ta_reg[i] <= side_reg[NW-1].neg_a[i] ? -ta_mag[i] : ta_mag[i];
                tb_reg[i] <= side_reg[NW-1].neg_b[i] ? -tb_mag[i] : tb_mag[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Post 2: order each slab, fold entry (max) and exit (min) over axes
    // ------------------------------------------------------------------
    logic signed [T_W-1:0] t1 [3];
    logic signed [T_W-1:0] t2 [3];
    logic signed [T_W-1:0] tnear;
    logic signed [T_W-1:0] tfar;
    logic signed [T_W-1:0] tnear_reg;
    logic signed [T_W-1:0] tfar_reg;
    aabb_pkg::side_t       p2_side_reg;
    logic                  p2_sph_reg;

    always_comb
    begin
        tnear = -aabb_pkg::T_LIMIT;
        tfar  = aabb_pkg::T_LIMIT;
        for (int i = 0; i < 3; i++)
        begin
            // Zero direction leaves the slab unbounded.
            if (p1_side_reg.zero_dir[i])
            begin
                t1[i] = -aabb_pkg::T_LIMIT;
                t2[i] = aabb_pkg::T_LIMIT;
            end
            else
            begin
                t1[i] = (ta_reg[i] < tb_reg[i]) ? ta_reg[i] : tb_reg[i];
                t2[i] = (ta_reg[i] < tb_reg[i]) ? tb_reg[i] : ta_reg[i];
            end
            if (t1[i] > tnear)
            begin
                tnear = t1[i];
            end
            if (t2[i] < tfar)
            begin
                tfar = t2[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_side_reg <= '0;
        end
        else if (adv)
        begin
            p2_side_reg <= p1_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tnear_reg  <= tnear;
            tfar_reg   <= tfar;
            p2_sph_reg <= p1_sph_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: pick the answer for the command
    // ------------------------------------------------------------------
    logic hit_next;

    always_comb
    begin
        unique case (p2_side_reg.cmd)
            aabb_pkg::CMD_SPHERE: hit_next = p2_sph_reg;
            aabb_pkg::CMD_BOX:    hit_next = p2_side_reg.box_hit;
            aabb_pkg::CMD_RAY:    hit_next = p2_side_reg.zero_ok && !(tnear_reg > tfar_reg)
                                             && !tfar_reg[T_W-1];
            default:              hit_next = 1'b0;  // unused command never hits
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= p2_side_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg <= hit_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

`ifndef SYNTH
    // The unused command code must come out as a miss.
    a_unused_cmd_miss: assert property (@(posedge clk) disable iff (!rst_n)
        adv && p2_side_reg.valid && (p2_side_reg.cmd == aabb_pkg::CMD_UNUSED) |=> !hit_reg)
        else $error("unused command produced a hit");

    // A ray whose exit lies behind the origin never hits.
    a_ray_behind_miss: assert property (@(posedge clk) disable iff (!rst_n)
        adv && p2_side_reg.valid && (p2_side_reg.cmd == aabb_pkg::CMD_RAY)
        && tfar_reg[T_W-1] |=> !hit_reg)
        else $error("ray with negative exit reported a hit");

    // Saturated slab parameters of axis 0 stay within the limits.
    a_t_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        p1_side_reg.valid |-> (ta_reg[0] <= aabb_pkg::T_LIMIT)
        && (ta_reg[0] >= -aabb_pkg::T_LIMIT) && (tb_reg[0] <= aabb_pkg::T_LIMIT)
        && (tb_reg[0] >= -aabb_pkg::T_LIMIT))
        else $error("slab parameter outside saturation limits");
`endif

endmodule

// ----- verif/aabb_intersection_tester_top_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the AABB intersection tester: sphere, box and ray
// queries against a configurable box, checked against a local predictor.
// Depends on aabb_pkg and aabb_intersection_tester_top.
module aabb_intersection_tester_top_test;

    localparam int IDX_W  = aabb_pkg::IDX_W;
    localparam int IN_W   = aabb_pkg::IN_W;
    localparam int CMD_W  = aabb_pkg::CMD_W;
    localparam int SIZE_W = aabb_pkg::SIZE_W;
    localparam longint T_MAX = 64'sd655360000000;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [IDX_W-1:0] cfg_index;
    logic [IN_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [CMD_W-1:0] command;
    logic signed [IN_W-1:0] operand_a_x, operand_a_y, operand_a_z;
    logic signed [IN_W-1:0] operand_b_x, operand_b_y, operand_b_z;
    logic [SIZE_W-1:0] radius;
    logic out_valid;
    logic out_ready;
    logic hit;

    // Local copy of the box registers.
    logic signed [31:0] box_center [3];
    logic [30:0] box_size [3];

    // Expected hit bits, oldest first.
    bit hit_queue [$];
    int error_count;

    aabb_intersection_tester_top dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard limit: covers the pipeline latency plus random idle gaps on both sides per item.
    initial
    begin
        #(20 * 200000);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // Predict one hit bit from the current box and the query fields.
    function automatic bit predict_hit(input logic [1:0] cmd, input logic signed [31:0] a [3],
                                       input logic signed [31:0] b [3], input logic [30:0] rad);
        longint lo [3];
        longint hi [3];
        longint d, ta, tb, t1, t2, tnear, tfar;
        logic [127:0] dist_sq, rad_sq;
        dist_sq = '0;
        tnear = -T_MAX;
        tfar = T_MAX;
        for (int i = 0; i < 3; i++)
        begin
            lo[i] = longint'(box_center[i]) - longint'(box_size[i] >> 1);
            hi[i] = longint'(box_center[i]) + longint'(box_size[i] >> 1);
        end
        case (cmd)
            aabb_pkg::CMD_SPHERE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    d = 0;
                    if (a[i] < lo[i])
                        d = lo[i] - a[i];
                    else if (a[i] > hi[i])
                        d = a[i] - hi[i];
                    dist_sq += 128'(d) * 128'(d);
                end
                rad_sq = 128'(rad) * 128'(rad);
                return dist_sq <= rad_sq;
            end
            aabb_pkg::CMD_BOX:
            begin
                for (int i = 0; i < 3; i++)
                    if (lo[i] > b[i] || a[i] > hi[i])
                        return 1'b0;
                return 1'b1;
            end
            aabb_pkg::CMD_RAY:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (b[i] == 0)
                    begin
                        if (a[i] < lo[i] || a[i] > hi[i])
                            return 1'b0;
                        continue;
                    end
                    // Dividends fit in 50 bits, so 64-bit math truncating toward zero is exact.
                    ta = ((lo[i] - a[i]) * 65536) / longint'(b[i]);
                    tb = ((hi[i] - a[i]) * 65536) / longint'(b[i]);
                    if (ta > T_MAX) ta = T_MAX;
                    if (ta < -T_MAX) ta = -T_MAX;
                    if (tb > T_MAX) tb = T_MAX;
                    if (tb < -T_MAX) tb = -T_MAX;
                    t1 = (ta < tb) ? ta : tb;
                    t2 = (ta < tb) ? tb : ta;
                    if (t1 > tnear) tnear = t1;
                    if (t2 < tfar) tfar = t2;
                    if (tnear > tfar || tfar < 0)
                        return 1'b0;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Send one item: idle a random gap, predict, then hold valid until accepted.
    // Valid stays high after acceptance; the next call or drain decides on it.
    task automatic send_query(input logic [1:0] cmd, input logic signed [31:0] a [3],
                              input logic signed [31:0] b [3], input logic [30:0] rad);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        hit_queue.push_back(predict_hit(cmd, a, b, rad));
        command <= cmd;
        operand_a_x <= a[0];
        operand_a_y <= a[1];
        operand_a_z <= a[2];
        operand_b_x <= b[0];
        operand_b_y <= b[1];
        operand_b_z <= b[2];
        radius <= rad;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Write one box register; only called while the pipeline is empty.
    // The caller drops the write enable after its last write.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        if (idx < aabb_pkg::REG_SIZE_X)
            box_center[idx] = value;
        else if (idx < aabb_pkg::NUM_REGS)
            box_size[idx - aabb_pkg::REG_SIZE_X] = value[30:0];
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (hit_queue.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_box(input logic signed [31:0] c [3], input logic [30:0] s [3]);
        drain();
        for (int i = 0; i < 3; i++)
        begin
            write_reg(IDX_W'(aabb_pkg::REG_CENTER_X + i), c[i]);
            write_reg(IDX_W'(aabb_pkg::REG_SIZE_X + i), {1'b0, s[i]});
        end
        cfg_write <= 1'b0;
    endtask

    // Coordinate draw: mostly near the box, sometimes full range or extremes.
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2, 3: return $urandom;
            default: return $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_dir();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom;
            2: return $signed($urandom_range(0, 8)) - 4;
            default: return $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
        endcase
    endfunction

    task automatic test_directed;
        logic signed [31:0] a [3];
        logic signed [31:0] b [3];
        // sphere touching the face exactly: distance 0.5, radius 0.5
        a = '{32'sh10000, 0, 0}; b = '{0, 0, 0};
        send_query(aabb_pkg::CMD_SPHERE, a, b, 31'h8000);
        send_query(aabb_pkg::CMD_SPHERE, a, b, 31'h7fff);
        a = '{32'sh80000000, 32'sh80000000, 32'sh7fffffff};
        send_query(aabb_pkg::CMD_SPHERE, a, b, 31'h7fffffff);
        send_query(aabb_pkg::CMD_SPHERE, a, b, 0);
        // box overlap: touching, separated, reversed
        a = '{32'sh8000, 0, 0}; b = '{32'sh10000, 1, 1};
        send_query(aabb_pkg::CMD_BOX, a, b, 0);
        a = '{32'sh8001, 0, 0};
        send_query(aabb_pkg::CMD_BOX, a, b, 31'h7fffffff);
        a = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
        b = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
        send_query(aabb_pkg::CMD_BOX, a, b, 0);
        send_query(aabb_pkg::CMD_BOX, b, a, 0);
        // rays: axis-aligned hit, behind origin, zero direction in and out of the slab
        a = '{-32'sh30000, 0, 0}; b = '{32'sh10000, 0, 0};
        send_query(aabb_pkg::CMD_RAY, a, b, 0);
        b = '{-32'sh10000, 0, 0};
        send_query(aabb_pkg::CMD_RAY, a, b, 0);
        a = '{0, 32'sh20000, 0}; b = '{32'sh10000, 0, 0};
        send_query(aabb_pkg::CMD_RAY, a, b, 0);
        a = '{0, 0, 0}; b = '{0, 0, 0};
        send_query(aabb_pkg::CMD_RAY, a, b, 0);
        // saturation: tiny direction from far away, huge direction
        a = '{32'sh80000000, 0, 0}; b = '{1, 0, 0};
        send_query(aabb_pkg::CMD_RAY, a, b, 0);
        b = '{32'sh7fffffff, 32'sh80000000, 1};
        send_query(aabb_pkg::CMD_RAY, a, b, 0);
        // unused command code
        a = '{0, 0, 0};
        send_query(aabb_pkg::CMD_UNUSED, a, b, 31'h7fffffff);
    endtask

    task automatic test_random(input int count);
        logic signed [31:0] a [3];
        logic signed [31:0] b [3];
        logic [1:0] cmd;
        for (int n = 0; n < count; n++)
        begin
            cmd = ($urandom_range(0, 19) == 0) ? aabb_pkg::CMD_UNUSED
                                               : 2'($urandom_range(0, 2));
            for (int i = 0; i < 3; i++)
            begin
                a[i] = rand_coord();
                b[i] = (cmd == aabb_pkg::CMD_RAY) ? rand_dir() : rand_coord();
                if (cmd == aabb_pkg::CMD_BOX && $urandom_range(0, 3) != 0 && a[i] > b[i])
                    b[i] = a[i] + $urandom_range(0, 32'h10000);
            end
            send_query(cmd, a, b,
                $urandom_range(0, 7) == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h30000)));
        end
    endtask

    // Sweep box settings: extremes, then random ones.
    task automatic test_box_settings;
        logic signed [31:0] c [3];
        logic [30:0] s [3];
        c = '{32'sh7fffffff, 32'sh80000000, 0}; s = '{31'h7fffffff, 0, 31'h7fffffff};
        set_box(c, s);
        test_random(150);
        c = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000}; s = '{0, 31'h7fffffff, 1};
        set_box(c, s);
        test_random(150);
        for (int k = 0; k < 6; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                c[i] = $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
                s[i] = (k == 5) ? 31'($urandom) : 31'($urandom_range(0, 32'h40000));
            end
            set_box(c, s);
            test_random(200);
        end
    endtask

    // Receive side: compare each result with the oldest expectation, then
    // drop ready for a random idle gap before taking the next one.
    initial
    begin
        bit want;
        int idle;
        out_ready = 1'b0;
        @(posedge rst_n);
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (hit_queue.size() == 0)
                    report_mismatch("hit result with nothing expected");
                else
                begin
                    want = hit_queue.pop_front();
                    if (hit !== want)
                        report_mismatch($sformatf("hit %b, expected %b", hit, want));
                end
                idle = $urandom_range(0, 10);
                if (idle != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (idle) @(posedge clk);
                    out_ready <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        command = '0;
        {operand_a_x, operand_a_y, operand_a_z} = '0;
        {operand_b_x, operand_b_y, operand_b_z} = '0;
        radius = '0;
        error_count = 0;
        for (int i = 0; i < 3; i++)
        begin
            box_center[i] = 0;
            box_size[i] = aabb_pkg::SIZE_RESET;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(150);
        // Hold off until the pipeline is empty, then keep going.
        drain();
        test_box_settings();
        drain();
        repeat (60) @(posedge clk);
        if (error_count == 0 && hit_queue.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
